FILE: rtl/mtc_pkg.sv
// Shared constants and types for the magnetometer trim compensation block.
// No dependencies; every module of the block imports this package.
package mtc_pkg;

	// Raw item layout and extracted widths.
	localparam int WORD_W = 16;
	localparam int R_W    = 14;

	// Pipelined divider size: wide enough for the z quotient magnitude.
	localparam int DIV_NUM_W = 34;
	localparam int DIV_DEN_W = 18;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Fixed-point constants of the compensation.
	localparam logic [15:0] TEMP_BIAS   = 16'h4000;
	localparam logic [25:0] XY_BASE     = 26'h100000;
	localparam logic [9:0]  GAIN_OFFSET = 10'h0A0;
	localparam logic [31:0] Z_ROUND     = 32'h0000_8000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_XY_TRIM   = 3'd0,
		REG_TRIM_Z1   = 3'd1,
		REG_TRIM_Z2   = 3'd2,
		REG_TRIM_Z3   = 3'd3,
		REG_TRIM_Z4   = 3'd4,
		REG_TRIM_XYZ1 = 3'd5
	} cfg_reg_t;

	// Per-item values that ride beside the dividers.
	typedef struct packed {
		logic signed [12:0] mx;
		logic signed [12:0] my;
		logic               xy_zero;
		logic               z_zero;
		logic               z_neg;
	} side_t;

endpackage

FILE: rtl/mtc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on mtc_pkg for default widths; stalls with the enclosing pipeline.
module mtc_div #(
	parameter int NUM_W = mtc_pkg::DIV_NUM_W,
	parameter int DEN_W = mtc_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	import mtc_pkg::*;

	// Each stage holds the partial remainder, the dividend bits not yet used
	// (shifted up) with the quotient bits filling in from below, and the divisor.
	logic [DEN_W-1:0] rem_sd [NUM_W];
	logic [NUM_W-1:0] nq_sd  [NUM_W];
	logic [DEN_W-1:0] den_sd [NUM_W];

	genvar i;
	generate
		for (i = 0; i < NUM_W; i++) begin : g_stage
			logic [DEN_W-1:0] rem_in;
			logic [NUM_W-1:0] nq_in;
			logic [DEN_W-1:0] den_in;
			logic [DEN_W:0]   trial;
			logic [DEN_W:0]   diff;
			logic             take;

			// Stage input comes from the previous stage or from the ports.
			if (i == 0) begin : g_first
				assign rem_in = '0;
				assign nq_in  = num;
				assign den_in = den;
			end else begin : g_next
				assign rem_in = rem_sd[i-1];
				assign nq_in  = nq_sd[i-1];
				assign den_in = den_sd[i-1];
			end

			// Shift in the next dividend bit and try the subtraction.
			always_comb begin
				trial = {rem_in, nq_in[NUM_W-1]};
				diff  = trial - {1'b0, den_in};
				take  = ~diff[DEN_W];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					nq_sd[i]  <= {nq_in[NUM_W-2:0], take};
					den_sd[i] <= den_in;
				end
			end
		end
	endgenerate

	assign quo = nq_sd[NUM_W-1];

endmodule

FILE: rtl/magnetometer_trim_compensation.sv
// Top level of the magnetometer trim compensation pipeline.
// Depends on mtc_pkg and on mtc_div for the two pipelined dividers.
//
//   channel   | direction | handshake                   | content
//   s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata: x, y, z, hall words
//   m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: field x, y, z; tuser: fault
//   cfg       | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One item enters per cycle unless the output is stalled; each result passes one
// input stage, 34 divider stages set by the z quotient width, four multiply stages
// and one output register. Items without data ready leave no result. Reset clears
// the trims and all valid bits. A stalled output holds the whole pipeline; nothing is lost.
module magnetometer_trim_compensation #(
	parameter int DIV_N = mtc_pkg::DIV_NUM_W,
	parameter int DIV_D = mtc_pkg::DIV_DEN_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [63:0]                         s_axis_tdata,  // x_word, y_word, z_word, hall_word
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [47:0]                         m_axis_tdata,  // field_x, field_y, field_z
	output logic                                m_axis_tuser,  // divide_fault
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mtc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mtc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mtc_pkg::*;

	// Trim registers.
	logic [47:0] xy_trim_q;
	logic [15:0] trim_z1_q, trim_z2_q, trim_z3_q, trim_z4_q, trim_xyz1_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_trim_q   <= '0;
			trim_z1_q   <= '0;
			trim_z2_q   <= '0;
			trim_z3_q   <= '0;
			trim_z4_q   <= '0;
			trim_xyz1_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_XY_TRIM:   xy_trim_q   <= cfg_data[47:0];
				REG_TRIM_Z1:   trim_z1_q   <= cfg_data[15:0];
				REG_TRIM_Z2:   trim_z2_q   <= cfg_data[15:0];
				REG_TRIM_Z3:   trim_z3_q   <= cfg_data[15:0];
				REG_TRIM_Z4:   trim_z4_q   <= cfg_data[15:0];
				REG_TRIM_XYZ1: trim_xyz1_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Byte trims.
	logic signed [7:0] off_x, off_y, gain_x, gain_y, xy2;
	logic        [7:0] xy1;
	assign off_x  = xy_trim_q[7:0];
	assign off_y  = xy_trim_q[15:8];
	assign gain_x = xy_trim_q[23:16];
	assign gain_y = xy_trim_q[31:24];
	assign xy1    = xy_trim_q[39:32];
	assign xy2    = xy_trim_q[47:40];

	// The whole pipeline advances together unless the output is blocked.
	logic adv;
	logic out_valid_q;
	assign adv           = ~out_valid_q | m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: field extraction, divider operands and the z products.
	logic [15:0]        x_word, y_word, z_word, hall_word;
	logic [R_W-1:0]     r_val;
	logic [15:0]        d_xy;
	logic [30:0]        pz1;
	logic signed [16:0] rdiff;
	logic signed [32:0] pz3;
	logic signed [16:0] mzd;

	assign x_word    = s_axis_tdata[15:0];
	assign y_word    = s_axis_tdata[31:16];
	assign z_word    = s_axis_tdata[47:32];
	assign hall_word = s_axis_tdata[63:48];

	always_comb begin
		r_val = hall_word[15:2];
		d_xy  = (r_val != '0) ? {2'b00, r_val} : trim_xyz1_q;
		pz1   = 31'(trim_z1_q) * 31'({r_val, 1'b0});
		rdiff = $signed({3'b000, r_val}) - $signed({trim_xyz1_q[15], trim_xyz1_q});
		pz3   = 33'($signed(trim_z3_q)) * 33'(rdiff);
		mzd   = $signed({{2{z_word[15]}}, z_word[15:1]})
			- $signed({trim_z4_q[15], trim_z4_q});
	end

	logic               v_s1;
	logic signed [12:0] mx_s1, my_s1;
	logic signed [16:0] mzd_s1;
	logic [30:0]        pz1_s1;
	logic signed [32:0] pz3_s1;
	logic [15:0]        num_xy_s1;
	logic [15:0]        d_xy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid & hall_word[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1     <= x_word[15:3];
			my_s1     <= y_word[15:3];
			mzd_s1    <= mzd;
			pz1_s1    <= pz1;
			pz3_s1    <= pz3;
			num_xy_s1 <= trim_xyz1_q;
			d_xy_s1   <= d_xy;
		end
	end

	// Z numerator and denominator, reduced to magnitudes for the divider.
	logic [31:0]        zsum;
	logic signed [17:0] zden;
	logic signed [33:0] znum;
	logic [DIV_N-1:0]   znum_abs;
	logic [DIV_D-1:0]   zden_abs;
	side_t              side_in;

	always_comb begin
		zsum     = {1'b0, pz1_s1} + Z_ROUND;
		zden     = $signed({{2{trim_z2_q[15]}}, trim_z2_q}) + $signed({2'b00, zsum[31:16]});
		znum     = $signed({{2{mzd_s1[16]}}, mzd_s1, 15'b0})
			- $signed({{3{pz3_s1[32]}}, pz3_s1[32:2]});
		znum_abs = DIV_N'(znum[33] ? -znum : znum);
		zden_abs = DIV_D'(zden[17] ? -zden : zden);
		side_in.mx      = mx_s1;
		side_in.my      = my_s1;
		side_in.xy_zero = (d_xy_s1 == '0);
		side_in.z_zero  = (zden == '0);
		side_in.z_neg   = znum[33] ^ zden[17];
	end

	// Two dividers of equal depth keep both quotients aligned.
	logic [DIV_N-1:0] quo_xy, quo_z;

	mtc_div #(.NUM_W(DIV_N), .DEN_W(DIV_D)) u_div_xy (
		.clk (clk),
		.en  (adv),
		.num (DIV_N'({num_xy_s1, 14'b0})),
		.den (DIV_D'(d_xy_s1)),
		.quo (quo_xy)
	);

	mtc_div #(.NUM_W(DIV_N), .DEN_W(DIV_D)) u_div_z (
		.clk (clk),
		.en  (adv),
		.num (znum_abs),
		.den (zden_abs),
		.quo (quo_z)
	);

	// Side values and valid bits travel beside the divider stages.
	side_t      side_sd [DIV_N];
	logic [DIV_N-1:0] v_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= '0;
		end else if (adv) begin
			v_sd <= {v_sd[DIV_N-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_in;
			for (int k = 1; k < DIV_N; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
		end
	end

	// Stage 3: temperature term and its square; z sign, and z forced to zero on a zero divisor.
	logic signed [15:0] temp;
	logic signed [31:0] sq;
	logic signed [24:0] txy;
	logic [15:0]        zq;

	always_comb begin
		temp = $signed(quo_xy[15:0] - TEMP_BIAS);
		sq   = 32'(temp) * 32'(temp);
		txy  = 25'(temp) * 25'($signed({1'b0, xy1}));
		zq   = quo_z[15:0];
	end

	logic               v_s3;
	side_t              side_s3;
	logic signed [31:0] sq_s3;
	logic signed [24:0] txy_s3;
	logic [15:0]        fz_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_sd[DIV_N-1];
			sq_s3   <= sq;
			txy_s3  <= txy;
			if (side_sd[DIV_N-1].z_zero) begin
				fz_s3 <= '0;
			end else begin
				fz_s3 <= side_sd[DIV_N-1].z_neg ? -zq : zq;
			end
		end
	end

	// Stage 4: combined temperature polynomial.
	logic signed [33:0] a_s4;
	side_t              side_s4;
	logic [15:0]        fz_s4;
	logic               v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4    <= 34'(xy2) * 34'($signed(sq_s3[31:7]))
				+ $signed({{2{txy_s3[24]}}, txy_s3, 7'b0});
			side_s4 <= side_s3;
			fz_s4   <= fz_s3;
		end
	end

	// Stage 5: per-axis scale factor.
	logic signed [25:0] base;
	logic signed [9:0]  gxp, gyp;

	always_comb begin
		base = $signed({a_s4[33], a_s4[33:9]}) + $signed(XY_BASE);
		gxp  = $signed({{2{gain_x[7]}}, gain_x}) + $signed(GAIN_OFFSET);
		gyp  = $signed({{2{gain_y[7]}}, gain_y}) + $signed(GAIN_OFFSET);
	end

	logic signed [35:0] bx_s5, by_s5;
	side_t              side_s5;
	logic [15:0]        fz_s5;
	logic               v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			bx_s5   <= 36'(base) * 36'(gxp);
			by_s5   <= 36'(base) * 36'(gyp);
			side_s5 <= side_s4;
			fz_s5   <= fz_s4;
		end
	end

	// Stage 6: scale the raw axis readings.
	logic signed [36:0] px_s6, py_s6;
	side_t              side_s6;
	logic [15:0]        fz_s6;
	logic               v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s6   <= 37'($signed(side_s5.mx)) * 37'($signed(bx_s5[35:12]));
			py_s6   <= 37'($signed(side_s5.my)) * 37'($signed(by_s5[35:12]));
			side_s6 <= side_s5;
			fz_s6   <= fz_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_sd[DIV_N-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Output register: add the offsets and apply the x/y fault.
	logic [15:0] fx, fy;
	logic [15:0] fx_q, fy_q, fz_q;
	logic        fault_q;

	always_comb begin
		fx = px_s6[28:13] + {{5{off_x[7]}}, off_x, 3'b000};
		fy = py_s6[28:13] + {{5{off_y[7]}}, off_y, 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_q    <= side_s6.xy_zero ? 16'h0000 : fx;
			fy_q    <= side_s6.xy_zero ? 16'h0000 : fy;
			fz_q    <= fz_s6;
			fault_q <= side_s6.xy_zero | side_s6.z_zero;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {fz_q, fy_q, fx_q};
	assign m_axis_tuser  = fault_q;

endmodule

FILE: test/tb_top.sv
// Testbench for the magnetometer trim compensation block: a scoreboard class
// predicts each compensated read from the trims; tasks drive the stream ports.
// Depends on mtc_pkg and the magnetometer_trim_compensation RTL.
`timescale 1ns / 1ps

module tb_top;
	import mtc_pkg::*;

	typedef struct {
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fz;
		logic        fault;
	} field_t;

	// Holds the trims, computes the expected fields and matches the results.
	class field_board;
		logic [47:0] xy_trim;
		logic [15:0] z1, z2, z3, z4, xyz1;
		field_t      pending[$];
		int          n_items;
		int          n_fields;

		function void clear();
			xy_trim = '0; z1 = '0; z2 = '0; z3 = '0; z4 = '0; xyz1 = '0;
			n_items = 0; n_fields = 0;
		endfunction

		function void write_trim(logic [2:0] idx, logic [47:0] val);
			case (idx)
				REG_XY_TRIM:   xy_trim = val;
				REG_TRIM_Z1:   z1 = val[15:0];
				REG_TRIM_Z2:   z2 = val[15:0];
				REG_TRIM_Z3:   z3 = val[15:0];
				REG_TRIM_Z4:   z4 = val[15:0];
				REG_TRIM_XYZ1: xyz1 = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] axis_field(longint raw, longint temp, longint off, longint gain);
			longint xy1, xy2, a, b, v;
			xy1 = longint'(xy_trim[39:32]);
			xy2 = longint'($signed(xy_trim[47:40]));
			a = xy2 * ((temp * temp) >>> 7) + temp * (xy1 * 128);
			b = (((a >>> 9) + 1048576) * (gain + 160)) >>> 12;
			v = ((raw * b) >>> 13) + off * 8;
			return v[15:0];
		endfunction

		// Notes one accepted raw read; queues a result when data ready is set.
		function void note_read(logic [63:0] d);
			longint mx, my, mz, r, rf, dv, q, temp, zden, znum, zq;
			logic [15:0] t16;
			field_t e;
			n_items++;
			if (!d[48])
				return;
			mx = longint'($signed(d[15:3]));
			my = longint'($signed(d[31:19]));
			mz = longint'($signed(d[47:33]));
			r = longint'(d[63:50]);
			rf = longint'(xyz1);
			e.fx = '0; e.fy = '0; e.fz = '0; e.fault = 1'b0;
			dv = (r != 0) ? r : rf;
			if (dv == 0) begin
				e.fault = 1'b1;
			end else begin
				q = (rf * 16384) / dv;
				t16 = q[15:0] - 16'h4000;
				temp = longint'($signed(t16));
				e.fx = axis_field(mx, temp, longint'($signed(xy_trim[7:0])),
					longint'($signed(xy_trim[23:16])));
				e.fy = axis_field(my, temp, longint'($signed(xy_trim[15:8])),
					longint'($signed(xy_trim[31:24])));
			end
			zden = longint'($signed(z2)) + ((longint'(z1) * (r * 2) + 32768) >>> 16);
			if (zden == 0) begin
				e.fault = 1'b1;
			end else begin
				znum = (mz - longint'($signed(z4))) * 32768 -
					((longint'($signed(z3)) * (r - longint'($signed(xyz1)))) >>> 2);
				zq = znum / zden;
				e.fz = zq[15:0];
			end
			pending.push_back(e);
		endfunction

		// Compares one result with the oldest expectation; msg is set on a mismatch.
		function bit check_field(logic [47:0] td, logic tu, output string msg);
			field_t e;
			msg = "";
			if (pending.size() == 0) begin
				msg = $sformatf("unexpected result %h fault %b", td, tu);
				return 0;
			end
			e = pending.pop_front();
			n_fields++;
			if (td[15:0] !== e.fx)
				msg = {msg, $sformatf(" x %h/%h", td[15:0], e.fx)};
			if (td[31:16] !== e.fy)
				msg = {msg, $sformatf(" y %h/%h", td[31:16], e.fy)};
			if (td[47:32] !== e.fz)
				msg = {msg, $sformatf(" z %h/%h", td[47:32], e.fz)};
			if (tu !== e.fault)
				msg = {msg, $sformatf(" fault %b/%b", tu, e.fault)};
			return msg == "";
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;  // x_word, y_word, z_word, hall_word
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // field_x, field_y, field_z
	logic        m_axis_tuser;  // divide_fault
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	field_board board;
	int errors;
	int send_idle;
	int recv_idle;

	magnetometer_trim_compensation uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task report(input string msg);
		errors++;
		$display("MISMATCH at %0t:%s", $realtime, msg);
	endtask

	// Receiver: checks each accepted result and stalls at random.
	initial begin
		string msg;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				if (!board.check_field(m_axis_tdata, m_axis_tuser, msg))
					report(msg);
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Presents one raw read, idling first at random, and waits for acceptance.
	task send_read(input logic [63:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		board.note_read(d);
	endtask

	task write_trim(input logic [2:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.write_trim(idx, val);
		@(posedge clk);
	endtask

	// Lets the pipeline empty, including reads that leave no result.
	task drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function logic [63:0] pack_read(logic [15:0] x, logic [15:0] y, logic [15:0] z,
		logic [15:0] h);
		return {h, z, y, x};
	endfunction

	function logic [63:0] rand_read();
		logic [15:0] h;
		h = 16'($urandom);
		h[0] = ($urandom_range(99) < 85);
		case ($urandom_range(9))
			0: h[15:2] = '0;
			1: h[15:2] = 14'h3FFF;
			2, 3, 4: h[15:2] = 14'($urandom_range(5000, 8000));
			default: ;
		endcase
		return pack_read(16'($urandom), 16'($urandom), 16'($urandom), h);
	endfunction

	// Sets all six trims for one phase of the run.
	task set_trims(input int kind);
		logic [47:0] w[6];
		for (int i = 0; i < 6; i++)
			w[i] = 48'({$urandom, $urandom});
		case (kind)
			0: begin
				w[0] = 48'hFFFF_FFFF_FFFF;
				w[1] = 48'hFFFF; w[2] = 48'h7FFF; w[3] = 48'h7FFF;
				w[4] = 48'h7FFF; w[5] = 48'hFFFF;
			end
			1: begin
				w[0] = 48'h8000_8080_8080;
				w[1] = '0; w[2] = 48'h8000; w[3] = 48'h8000;
				w[4] = 48'h8000; w[5] = '0;
			end
			2: begin
				w[1] = '0; w[2] = '0;
			end
			default: begin
				w[1][15:0] = 16'($urandom_range(20000, 40000));
				w[5][15:0] = 16'($urandom_range(5000, 8000));
			end
		endcase
		write_trim(REG_XY_TRIM, w[0]);
		write_trim(REG_TRIM_Z1, w[1]);
		write_trim(REG_TRIM_Z2, w[2]);
		write_trim(REG_TRIM_Z3, w[3]);
		write_trim(REG_TRIM_Z4, w[4]);
		write_trim(REG_TRIM_XYZ1, w[5]);
		write_trim(3'd6, 48'({$urandom, $urandom}));
		write_trim(3'd7, 48'({$urandom, $urandom}));
	endtask

	initial begin
		board = new();
		board.clear();
		errors = 0;
		send_idle = 37;
		recv_idle = 76;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset trims: both divisors zero, so every ready read faults.
		send_read(pack_read(16'h0000, 16'h0000, 16'h0000, 16'h0001));
		send_read(pack_read(16'h1234, 16'h5678, 16'h9ABC, 16'hFFFE));
		drain();

		// Directed reads under extreme and typical trims.
		for (int k = 0; k < 4; k++) begin
			set_trims(k == 3 ? 4 : k);
			send_read(pack_read(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
			send_read(pack_read(16'h8000, 16'h8000, 16'h8000, 16'h0001));
			send_read(pack_read(16'hFFFF, 16'h0007, 16'h0001, 16'h5AA5));
			send_read(pack_read(16'h0000, 16'hFFF8, 16'hFFFE, 16'hA5A8));
			send_read(pack_read(16'h1111, 16'h2222, 16'h3333, 16'h6001));
			drain();
		end

		// Random reads across trim settings and idling patterns.
		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				send_idle = 76; recv_idle = 37;
			end else if (p == 6) begin
				send_idle = 0; recv_idle = 0;
			end
			set_trims(p < 3 ? p : 3 + p);
			for (int i = 0; i < 210; i++)
				send_read(rand_read());
			drain();
		end

		$display("Covered %0d raw reads and %0d compensated results over 13 trim settings.",
			board.n_items, board.n_fields);
		if (errors == 0)
			$display("magnetometer_trim_compensation test passed");
		else
			$display("magnetometer_trim_compensation test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("magnetometer_trim_compensation test failed");
		$finish;
	end

endmodule
